// File: rtl/csw_pkg.sv
// ----------------------------------------------------------------------------
// csw_pkg
// shared types and constants of the class score window argmax block
// ----------------------------------------------------------------------------
package csw_pkg;

  localparam int unsigned NUM_CLASSES = 20;
  // window length must stay a power of two: the average is a right shift
  localparam int unsigned WINDOW_LEN  = 8;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CLS_W    = $clog2(NUM_CLASSES);
  localparam int unsigned IDX_W    = $clog2(NUM_CLASSES + 1);
  localparam int unsigned PTR_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned FILL_W   = $clog2(WINDOW_LEN + 1);
  localparam int unsigned AVG_SH   = $clog2(WINDOW_LEN);
  localparam int unsigned SUM_W    = SAMPLE_W + AVG_SH;
  localparam int unsigned DEPTH    = NUM_CLASSES * WINDOW_LEN;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 16'd26214;  // floor(0.4 * 2^16)

  localparam logic KIND_DETECT = 1'b0;
  localparam logic KIND_TRACK  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NEWEST,
    ST_SWEEP,
    ST_DONE
  } csw_state_e;

endpackage

// File: rtl/class_score_window_argmax_top.sv
// ----------------------------------------------------------------------------
// class_score_window_argmax_top
// per-class moving window of probability samples with argmax over the sums
// ----------------------------------------------------------------------------
// throughput: one request in flight at a time; the input stays blocked from
//   accept until the result is loaded, which also waits on a stalled output;
//   the sweep takes one class window per cycle through the sample memory read port
// reset: rst_ni async active low; windows read as zero until filled (fill
//   count), best class = last class, show = 0, threshold = 26214
// ----------------------------------------------------------------------------
module class_score_window_argmax_top
  import csw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [SAMPLE_W-1:0] cfg_wdata_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic [4:0]          class_index_i,
  input  logic                class_known_i,
  input  logic [SAMPLE_W-1:0] probability_i,
  input  logic [SAMPLE_W-1:0] confidence_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [4:0]          best_class_o,
  output logic [SAMPLE_W-1:0] best_average_o,
  output logic                show_o
);

  csw_state_e state_q, state_d;

  // configuration register
  logic [SAMPLE_W-1:0] thr_q;

  // captured request
  logic                kind_q;
  logic                conf_low_q;
  logic [SAMPLE_W-1:0] prob_q;
  logic [CLS_W-1:0]    target_q;
  logic                has_target_q;
  logic [SAMPLE_W-1:0] sample_q;

  // persistent state
  logic [CLS_W-1:0]    cur_best_q;
  logic                show_flag_q;
  logic [PTR_W-1:0]    ptr_q;       // ring slot receiving this request's sample
  logic [FILL_W-1:0]   fill_q;      // requests since reset, saturating
  logic [SUM_W-1:0]    sums_q [NUM_CLASSES];

  // sweep state
  logic [IDX_W-1:0]    idx_q;
  logic [CLS_W-1:0]    best_q;
  logic [SUM_W-1:0]    best_sum_q;

  // output register
  logic                out_valid_q;
  logic [4:0]          out_class_q;
  logic [SAMPLE_W-1:0] out_avg_q;

  // sample memory
  logic [SAMPLE_W-1:0] sample_mem_q [DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;
  logic [ADDR_W-1:0]   raddr;
  logic [ADDR_W-1:0]   waddr;
  logic                mem_we;
  logic [SAMPLE_W-1:0] wdata;

  logic                accept;
  logic                out_free;
  logic [PTR_W-1:0]    ptr_prev;
  logic [PTR_W-1:0]    ptr_next;
  logic [CLS_W-1:0]    pidx;
  logic                proc_en;
  logic [SAMPLE_W-1:0] old_s;
  logic [SAMPLE_W-1:0] fresh_s;
  logic [SUM_W-1:0]    new_sum;

  function automatic logic [ADDR_W-1:0] mem_addr(logic [CLS_W-1:0] cls, logic [PTR_W-1:0] slot);
    mem_addr = ADDR_W'(cls) * ADDR_W'(WINDOW_LEN) + ADDR_W'(slot);
  endfunction

  assign accept   = in_valid_i & in_ready_o;
  assign out_free = ~out_valid_q | out_ready_i;

  // ring pointer neighbors
  assign ptr_prev = (ptr_q == '0) ? PTR_W'(WINDOW_LEN - 1) : ptr_q - PTR_W'(1);
  assign ptr_next = (ptr_q == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_q + PTR_W'(1);

  // class being retired/updated this cycle lags the read by one
  assign pidx    = CLS_W'(idx_q - IDX_W'(1));
  assign proc_en = (state_q == ST_SWEEP) && (idx_q != '0);
  // oldest slot only holds a sample once the window has filled
  assign old_s   = (fill_q == FILL_W'(WINDOW_LEN)) ? rdata_q : '0;
  assign fresh_s = (has_target_q && (target_q == pidx)) ? sample_q : '0;
  assign new_sum = sums_q[pidx] - SUM_W'(old_s) + SUM_W'(fresh_s);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_NEWEST;
      ST_NEWEST: state_d = ST_SWEEP;
      ST_SWEEP:  if (idx_q == IDX_W'(NUM_CLASSES)) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = 1'b0;
    raddr      = '0;
    mem_we     = 1'b0;
    waddr      = mem_addr(pidx, ptr_q);
    wdata      = fresh_s;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        // newest sample of the current best class, for a repeating track step
        raddr      = mem_addr(cur_best_q, ptr_prev);
      end
      ST_SWEEP: begin
        if (idx_q < IDX_W'(NUM_CLASSES)) begin
          raddr = mem_addr(CLS_W'(idx_q), ptr_q);
        end
        mem_we = proc_en;
      end
      default: begin
      end
    endcase
  end

  // sample memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sample_mem_q[waddr] <= wdata;
    end
    rdata_q <= sample_mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // request capture and sample selection (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q     <= kind_i;
      prob_q     <= probability_i;
      conf_low_q <= (confidence_i < thr_q);
      if (kind_i == KIND_DETECT) begin
        // unknown or out of range class: every class gets zero
        has_target_q <= class_known_i && (class_index_i < 5'(NUM_CLASSES));
        target_q     <= CLS_W'(class_index_i);
      end else begin
        has_target_q <= 1'b1;
        target_q     <= cur_best_q;
      end
    end
    if (state_q == ST_NEWEST) begin
      if (kind_q == KIND_DETECT) begin
        sample_q <= prob_q;
      end else if (conf_low_q || (fill_q == '0)) begin
        sample_q <= '0;
      end else begin
        sample_q <= rdata_q;
      end
    end
  end

  // sweep counter and running argmax
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      best_q     <= '0;
      best_sum_q <= '0;
    end else if (state_q == ST_NEWEST) begin
      idx_q      <= '0;
      best_q     <= '0;
      best_sum_q <= '0;
    end else if (state_q == ST_SWEEP) begin
      if (idx_q != IDX_W'(NUM_CLASSES)) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      // ties go to the higher index
      if (proc_en && (new_sum >= best_sum_q)) begin
        best_q     <= pidx;
        best_sum_q <= new_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        sums_q[i] <= '0;
      end
    end else if (proc_en) begin
      sums_q[pidx] <= new_sum;
    end
  end

  // commit at end of request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_best_q  <= CLS_W'(NUM_CLASSES - 1);
      show_flag_q <= 1'b0;
      ptr_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == ST_DONE) && out_free) begin
        cur_best_q  <= best_q;
        show_flag_q <= (kind_q == KIND_DETECT) ? 1'b1 : ~conf_low_q;
        ptr_q       <= ptr_next;
        if (fill_q != FILL_W'(WINDOW_LEN)) begin
          fill_q <= fill_q + FILL_W'(1);
        end
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      out_class_q <= 5'(best_q);
      out_avg_q   <= SAMPLE_W'(best_sum_q >> AVG_SH);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign best_class_o   = out_class_q;
  assign best_average_o = out_avg_q;
  // show flag only changes when a new result is loaded
  assign show_o         = show_flag_q;

  // a request blocks the input for the rest of its work
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input ready right after an accepted request");

  // the memory is only written during the sweep, one class behind the read
  a_write_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_SWEEP) && (idx_q != '0) && (idx_q <= IDX_W'(NUM_CLASSES)))
    else $error("sample memory written outside the sweep");

  // reported class is always a real class
  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (best_class_o < 5'(NUM_CLASSES)) && (cur_best_q < CLS_W'(NUM_CLASSES)))
    else $error("best class out of range");

  // the fill count never passes the window length
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(WINDOW_LEN))
    else $error("fill count beyond window length");

endmodule

// File: verif/class_score_window_argmax_top_test.sv
// ----------------------------------------------------------------------------
// class_score_window_argmax_top_test
// self-checking bench for the per-class window smoother and its argmax
//
// Requests go in through a valid/ready port with random gaps. Results leave
// through a port whose ready stalls at random. A small class mirrors the
// per-class sample windows and their sums. For each accepted request it
// computes the expected best class, average and show flag and queues them.
// Every result is compared field by field against the oldest queued
// expectation. The threshold register is rewritten between phases, only
// while nothing is in flight, and covers both extremes.
// ----------------------------------------------------------------------------
module class_score_window_argmax_top_test
  import csw_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HALF_PERIOD    = 6;
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int unsigned DRAIN_CYCLES   = 40;    // extra wait after the final drain, for stray results
  localparam int unsigned PHASE_ITEMS    = 75;    // six random phases, about 450 requests

  // one request as it crosses the input port
  typedef struct packed {
    logic                kind;
    logic [4:0]          class_index;
    logic                known;
    logic [SAMPLE_W-1:0] probability;
    logic [SAMPLE_W-1:0] confidence;
  } request_t;

  // one expected result
  typedef struct packed {
    logic [4:0]          best_class;
    logic [SAMPLE_W-1:0] best_average;
    logic                show;
  } vote_t;

  // --------------------------------------------------------------------------
  // mirror of the class windows, plus the queue of results still owed
  // --------------------------------------------------------------------------
  class class_vote_model;
    logic [SAMPLE_W-1:0] windows[NUM_CLASSES][WINDOW_LEN];  // slot 0 is the newest
    logic [SUM_W-1:0]    sums[NUM_CLASSES];
    logic [CLS_W-1:0]    leader;
    logic                shown;
    logic [SAMPLE_W-1:0] threshold;
    vote_t               owed_votes[$];
    int                  fails;

    function new();
      for (int c = 0; c < NUM_CLASSES; c++) begin
        sums[c] = '0;
        for (int k = 0; k < WINDOW_LEN; k++) windows[c][k] = '0;
      end
      leader    = CLS_W'(NUM_CLASSES - 1);
      shown     = 1'b0;
      threshold = THRESHOLD_RESET;
      fails     = 0;
    endfunction

    function int owed();
      return owed_votes.size();
    endfunction

    // every window moves by one; only the target class can get a nonzero sample
    function void shift_windows(int target, logic [SAMPLE_W-1:0] fresh);
      logic [SAMPLE_W-1:0] incoming;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        incoming = (c == target) ? fresh : '0;
        sums[c]  = sums[c] - windows[c][WINDOW_LEN-1];
        for (int k = WINDOW_LEN - 1; k > 0; k--) windows[c][k] = windows[c][k-1];
        windows[c][0] = incoming;
        sums[c]       = sums[c] + incoming;
      end
    endfunction

    // >= so that ties go to the higher class
    function void elect_leader();
      logic [SUM_W-1:0] top_sum;
      top_sum = '0;
      leader  = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (sums[c] >= top_sum) begin
          top_sum = sums[c];
          leader  = CLS_W'(c);
        end
      end
    endfunction

    function void absorb_request(request_t req);
      int                  target;
      logic [SAMPLE_W-1:0] fresh;
      vote_t               vote;
      if (req.kind == KIND_DETECT) begin
        // unknown label or class past the end: nobody gets the probability
        target = (req.known && req.class_index < NUM_CLASSES) ?
                 int'(req.class_index) : NUM_CLASSES;
        fresh  = req.probability;
        shown  = 1'b1;
      end else if (req.confidence < threshold) begin
        target = int'(leader);
        fresh  = '0;
        shown  = 1'b0;
      end else begin
        target = int'(leader);
        fresh  = windows[leader][0];
        shown  = 1'b1;
      end
      shift_windows(target, fresh);
      elect_leader();
      vote.best_class   = leader;
      vote.best_average = SAMPLE_W'(sums[leader] / WINDOW_LEN);
      vote.show         = shown;
      owed_votes.push_back(vote);
    endfunction

    function void match_vote(logic [4:0] cls, logic [SAMPLE_W-1:0] avg, logic show_seen);
      vote_t want;
      if (owed_votes.size() == 0) begin
        $error("result with no request outstanding: best_class %0d best_average %0d show %0d",
               cls, avg, show_seen);
        fails++;
        return;
      end
      want = owed_votes.pop_front();
      if (cls !== want.best_class) begin
        $error("best_class: expected %0d, actual %0d", want.best_class, cls);
        fails++;
      end
      if (avg !== want.best_average) begin
        $error("best_average: expected %0d, actual %0d", want.best_average, avg);
        fails++;
      end
      if (show_seen !== want.show) begin
        $error("show: expected %0d, actual %0d", want.show, show_seen);
        fails++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports
  // --------------------------------------------------------------------------
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [SAMPLE_W-1:0] cfg_wdata_i   = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic                kind_i        = KIND_DETECT;
  logic [4:0]          class_index_i = '0;
  logic                class_known_i = 1'b0;
  logic [SAMPLE_W-1:0] probability_i = '0;
  logic [SAMPLE_W-1:0] confidence_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [4:0]          best_class_o;
  logic [SAMPLE_W-1:0] best_average_o;
  logic                show_o;

  class_vote_model votes;

  // sender pacing: while send_calm counts down, requests go back to back
  int send_calm = 0;
  // focus classes get most detections so windows fill and ties show up
  logic [4:0] focus_a = 5'd0;
  logic [4:0] focus_b = 5'd19;

  always #HALF_PERIOD clk_i = ~clk_i;

  class_score_window_argmax_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .class_index_i  (class_index_i),
    .class_known_i  (class_known_i),
    .probability_i  (probability_i),
    .confidence_i   (confidence_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .best_class_o   (best_class_o),
    .best_average_o (best_average_o),
    .show_o         (show_o)
  );

  // mostly no gap or a short one, now and then a long one
  function automatic int pick_pause();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // --------------------------------------------------------------------------
  // result side: random stalls on out_ready_i, with calm stretches in between
  // --------------------------------------------------------------------------
  int ready_stall = 0;
  int ready_calm  = 0;

  always @(posedge clk_i) begin
    if (ready_stall > 0) begin
      out_ready_i <= 1'b0;
      ready_stall <= ready_stall - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (ready_calm > 0) begin
        ready_calm <= ready_calm - 1;
      end else if ($urandom_range(0, 99) < 25) begin
        ready_stall <= $urandom_range(0, 9) == 0 ? $urandom_range(15, 60) :
                                                   $urandom_range(1, 3);
      end else if ($urandom_range(0, 99) < 3) begin
        ready_calm <= $urandom_range(40, 150);
      end
    end
  end

  // every accepted result is checked against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      votes.match_vote(best_class_o, best_average_o, show_o);
    end
  end

  // watchdog: too long without any request or result crossing a port
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  // present one request, hold it until accepted, then book it in the model
  // (booked here rather than in a monitor so that owed() is never behind)
  task automatic send_request(request_t req);
    int gap;
    if (send_calm > 0) begin
      gap       = 0;
      send_calm = send_calm - 1;
    end else begin
      gap = pick_pause();
      if ($urandom_range(0, 99) < 3) send_calm = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= req.kind;
    class_index_i <= req.class_index;
    class_known_i <= req.known;
    probability_i <= req.probability;
    confidence_i  <= req.confidence;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    votes.absorb_request(req);
  endtask

  // ignored fields carry random junk so their bits toggle too
  task automatic detect(logic [4:0] cls, logic known, logic [SAMPLE_W-1:0] prob);
    request_t req;
    req.kind        = KIND_DETECT;
    req.class_index = cls;
    req.known       = known;
    req.probability = prob;
    req.confidence  = SAMPLE_W'($urandom);
    send_request(req);
  endtask

  task automatic track(logic [SAMPLE_W-1:0] conf);
    request_t req;
    req.kind        = KIND_TRACK;
    req.class_index = 5'($urandom);
    req.known       = 1'($urandom);
    req.probability = SAMPLE_W'($urandom);
    req.confidence  = conf;
    send_request(req);
  endtask

  // drop valid and hold off until every owed result has been taken
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (votes.owed() != 0);
  endtask

  // only called with the block idle
  task automatic write_threshold(logic [SAMPLE_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i        <= 1'b0;
    votes.threshold = value;
  endtask

  // confidence that often lands right at the threshold edge
  function automatic logic [SAMPLE_W-1:0] pick_confidence();
    int edge_val;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: begin
        edge_val = int'(votes.threshold) + $urandom_range(0, 2) - 1;
        if (edge_val < 0) edge_val = 0;
        if (edge_val > 65535) edge_val = 65535;
        return SAMPLE_W'(edge_val);
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic request_t random_request();
    request_t req;
    int       roll;
    req.kind = ($urandom_range(0, 99) < 55) ? KIND_DETECT : KIND_TRACK;
    roll = $urandom_range(0, 99);
    if (roll < 35)      req.class_index = focus_a;
    else if (roll < 70) req.class_index = focus_b;
    else if (roll < 90) req.class_index = 5'($urandom_range(0, NUM_CLASSES - 1));
    else                req.class_index = 5'($urandom_range(NUM_CLASSES, 31));
    req.known = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 5))
      0:       req.probability = '0;
      1:       req.probability = '1;
      2:       req.probability = 16'd4096;  // shared value breeds equal sums
      default: req.probability = SAMPLE_W'($urandom);
    endcase
    req.confidence = pick_confidence();
    return req;
  endfunction

  task automatic random_phase(int count);
    focus_a = 5'($urandom_range(0, NUM_CLASSES - 1));
    focus_b = 5'($urandom_range(0, NUM_CLASSES - 1));
    for (int i = 0; i < count; i++) begin
      send_request(random_request());
      // now and then let the pipeline run dry before going on
      if ($urandom_range(0, 39) == 0) drain_results();
    end
  endtask

  task automatic directed_phase();
    // all windows empty: last class, average zero
    track(16'd0);
    track(16'hFFFF);
    // full scale detection, then tracking repeats it
    detect(5'd0, 1'b1, 16'hFFFF);
    track(16'hFFFF);
    // confidence exactly at the threshold repeats, one below inserts zero
    track(THRESHOLD_RESET);
    track(THRESHOLD_RESET - 16'd1);
    // unknown label and out of range classes feed nobody but still show
    detect(5'd5, 1'b0, 16'd1234);
    detect(5'd20, 1'b1, 16'd40000);
    detect(5'd31, 1'b1, 16'hFFFF);
    detect(5'd19, 1'b1, 16'hFFFF);
    detect(5'd19, 1'b1, 16'd0);
    // equal samples on classes 3 and 7; classes 0 and 19 tie meanwhile, higher one wins
    detect(5'd3, 1'b1, 16'd100);
    detect(5'd7, 1'b1, 16'd100);
    detect(5'd10, 1'b1, 16'd1);
    // low confidence flushes every window back to zero
    repeat (WINDOW_LEN) track(16'd0);
    detect(5'd0, 1'b1, 16'd0);
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    votes = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset threshold first, then every phase under a new one
    directed_phase();

    drain_results();
    write_threshold(16'd0);        // every tracking step repeats
    random_phase(PHASE_ITEMS);

    drain_results();
    write_threshold(16'hFFFF);     // only full confidence repeats
    random_phase(PHASE_ITEMS);

    drain_results();
    write_threshold(16'd1);
    random_phase(PHASE_ITEMS);

    drain_results();
    write_threshold(SAMPLE_W'($urandom_range(2, 65533)));
    random_phase(PHASE_ITEMS);

    drain_results();
    write_threshold(THRESHOLD_RESET);
    random_phase(PHASE_ITEMS);

    drain_results();
    write_threshold(16'hFFFE);
    random_phase(PHASE_ITEMS);

    // wait for the last results, then a little longer for strays
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (votes.fails == 0 && votes.owed() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
